>>> rtl/core/tts_pkg.sv
// Shared types, codes and constants for the timed task slot scheduler.
`default_nettype none

package tts_pkg;

	localparam int NUM_SLOTS = 8;
	localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int MAX_OUT   = 8;
	localparam int CNT_W     = $clog2(MAX_OUT);

	// request codes
	localparam logic [1:0] REQ_ADD      = 2'd0;
	localparam logic [1:0] REQ_DELETE   = 2'd1;
	localparam logic [1:0] REQ_TICK     = 2'd2;
	localparam logic [1:0] REQ_DISPATCH = 2'd3;

	// result codes
	localparam logic [2:0] KIND_ADDED     = 3'd0;
	localparam logic [2:0] KIND_FULL      = 3'd1;
	localparam logic [2:0] KIND_DELETED   = 3'd2;
	localparam logic [2:0] KIND_NOT_FOUND = 3'd3;
	localparam logic [2:0] KIND_TICKED    = 3'd4;
	localparam logic [2:0] KIND_DUE       = 3'd5;
	localparam logic [2:0] KIND_NONE_DUE  = 3'd6;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] delay_ticks;
		logic [31:0] period_ticks;
		logic [15:0] task_handle;
		logic [7:0]  slot_id;
	} req_t;

	typedef struct packed {
		logic [2:0]  result_kind;
		logic [2:0]  slot_index;
		logic [15:0] due_handle;
		logic        last;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic       load;
		logic       adv;
		logic       add_wr;
		logic       take;
		logic       tick;
		logic       del;
		logic       push;
		logic [2:0] kind;
		logic       last;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] req_type;
		logic       free;
		logic       hit;
		logic       idx_last;
		logic       cnt_last;
		logic       pend_valid;
		logic       can_push;
		logic       del_ok;
	} sts_t;

	// slot number as carried on the result: low three bits only
	function automatic logic [2:0] slot_out(input logic [SLOT_W-1:0] s);
		logic [31:0] w;
		w = 32'(s);
		return w[2:0];
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/timed_task_slot_scheduler.sv
// Top level of the timed task slot scheduler: FSM plus slot datapath.
// Sequence: tick and delete give their single item from ST_ONE; add scans for a free
//   slot (the free-slot scan reads one slot a cycle), then waits for the result register;
//   dispatch scans for due slots, one slot per cycle unless a held result cannot be pushed.
// Throughput: one request in flight; the next is taken once the last result is registered.
// Reset: arst_n clears time, slot active bits and control; slot contents need no reset.
`default_nettype none

module timed_task_slot_scheduler (
	input  wire logic          clk,
	input  wire logic          arst_n,
	// request channel
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire tts_pkg::req_t req,
	// result channel
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output tts_pkg::rsp_t      rsp
);

	tts_pkg::cmd_t cmd;
	tts_pkg::sts_t sts;

	// Controller walks the table one slot per cycle for add, and for dispatch unless
	// a held result cannot be pushed. During dispatch one due slot is held back so
	// that its last flag is known once the scan shows whether any later slot is due.
	tts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req.req_type),
		.sts       (sts),
		.cmd       (cmd),
		.req_stall (req_stall)
	);

	// Datapath: slot table, time counter and the result register that
	// decouples the scan from a stalled consumer.
	tts_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

	// Only dispatch can give more than one item per request.
	a_notlast_is_due: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.last) |-> (rsp.result_kind == tts_pkg::KIND_DUE))
		else $error("non-final result is not a due task");

	// An accepted request blocks the next until its results are done.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request port free straight after acceptance");

	// Results that carry no slot carry zero in slot and handle.
	a_empty_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp.result_kind == tts_pkg::KIND_FULL ||
			rsp.result_kind == tts_pkg::KIND_NOT_FOUND ||
			rsp.result_kind == tts_pkg::KIND_TICKED ||
			rsp.result_kind == tts_pkg::KIND_NONE_DUE))
		|-> (rsp.slot_index == 3'd0 && rsp.due_handle == 16'd0))
		else $error("empty result carries slot or handle");

endmodule

`default_nettype wire

>>> rtl/core/tts_ctrl.sv
// Sequencing FSM for the timed task slot scheduler.
`default_nettype none

module tts_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	input  wire logic [1:0]    req_type,
	input  wire tts_pkg::sts_t sts,
	output tts_pkg::cmd_t      cmd,
	output logic               req_stall
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ONE,
		ST_ADD,
		ST_DISP,
		ST_FIN
	} state_t;

	state_t state_q;
	state_t state_d;

	assign req_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					case (req_type)
						tts_pkg::REQ_ADD:      state_d = ST_ADD;
						tts_pkg::REQ_DISPATCH: state_d = ST_DISP;
						default:               state_d = ST_ONE;
					endcase
				end
			end
			ST_ONE: begin
				if (sts.can_push) begin
					cmd.push = 1'b1;
					cmd.last = 1'b1;
					if (sts.req_type == tts_pkg::REQ_TICK) begin
						cmd.tick = 1'b1;
						cmd.kind = tts_pkg::KIND_TICKED;
					end else if (sts.del_ok) begin
						cmd.del  = 1'b1;
						cmd.kind = tts_pkg::KIND_DELETED;
					end else begin
						cmd.kind = tts_pkg::KIND_NOT_FOUND;
					end
					state_d = ST_IDLE;
				end
			end
			ST_ADD: begin
				if (sts.free) begin
					if (sts.can_push) begin
						cmd.add_wr = 1'b1;
						cmd.push   = 1'b1;
						cmd.kind   = tts_pkg::KIND_ADDED;
						cmd.last   = 1'b1;
						state_d    = ST_IDLE;
					end
				end else if (sts.idx_last) begin
					if (sts.can_push) begin
						cmd.push = 1'b1;
						cmd.kind = tts_pkg::KIND_FULL;
						cmd.last = 1'b1;
						state_d  = ST_IDLE;
					end
				end else begin
					cmd.adv = 1'b1;
				end
			end
			ST_DISP: begin
				if (sts.hit) begin
					// a held result goes out, not last, as the next due slot is taken
					if (!sts.pend_valid || sts.can_push) begin
						cmd.take = 1'b1;
						if (sts.pend_valid) begin
							cmd.push = 1'b1;
							cmd.kind = tts_pkg::KIND_DUE;
						end
						if (sts.idx_last || sts.cnt_last) begin
							state_d = ST_FIN;
						end else begin
							cmd.adv = 1'b1;
						end
					end
				end else if (sts.idx_last) begin
					state_d = ST_FIN;
				end else begin
					cmd.adv = 1'b1;
				end
			end
			ST_FIN: begin
				if (sts.can_push) begin
					cmd.push = 1'b1;
					cmd.last = 1'b1;
					cmd.kind = sts.pend_valid ? tts_pkg::KIND_DUE : tts_pkg::KIND_NONE_DUE;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/tts_dp.sv
// Slot table, time counter, scan counter and result register.
`default_nettype none

module tts_dp (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire tts_pkg::req_t req,
	input  wire tts_pkg::cmd_t cmd,
	input  wire logic          rsp_stall,
	output tts_pkg::sts_t      sts,
	output logic               rsp_valid,
	output tts_pkg::rsp_t      rsp
);

	localparam int N  = tts_pkg::NUM_SLOTS;
	localparam int SW = tts_pkg::SLOT_W;
	localparam int CW = tts_pkg::CNT_W;

	tts_pkg::req_t   req_q;
	logic [31:0]     now_q;
	logic [N-1:0]    active_q;
	logic [31:0]     due_q [N];
	logic [31:0]     per_q [N];
	logic [15:0]     hdl_q [N];
	logic [SW-1:0]   idx_q;
	logic [CW-1:0]   cnt_q;
	logic            pend_valid_q;
	logic [SW-1:0]   pend_idx_q;
	logic [15:0]     pend_hdl_q;
	logic            rsp_valid_q;
	tts_pkg::rsp_t   rsp_q;

	logic [31:0]     cur_due;
	logic [31:0]     cur_per;
	logic [SW-1:0]   del_sel;
	logic            del_range;
	logic            can_push;
	tts_pkg::rsp_t   rsp_d;

	assign cur_due   = due_q[idx_q];
	assign cur_per   = per_q[idx_q];
	assign del_sel   = req_q.slot_id[SW-1:0];
	assign del_range = (9'(req_q.slot_id) < 9'(N));
	assign can_push  = !rsp_valid_q || !rsp_stall;

	always_comb begin
		sts            = '0;
		sts.req_type   = req_q.req_type;
		sts.free       = !active_q[idx_q];
		sts.hit        = active_q[idx_q] && (cur_due <= now_q);
		sts.idx_last   = (idx_q == SW'(N - 1));
		sts.cnt_last   = (cnt_q == CW'(tts_pkg::MAX_OUT - 1));
		sts.pend_valid = pend_valid_q;
		sts.can_push   = can_push;
		sts.del_ok     = del_range && active_q[del_sel];
	end

	always_comb begin
		rsp_d             = '0;
		rsp_d.result_kind = cmd.kind;
		rsp_d.last        = cmd.last;
		case (cmd.kind)
			tts_pkg::KIND_ADDED: begin
				rsp_d.slot_index = tts_pkg::slot_out(idx_q);
				rsp_d.due_handle = req_q.task_handle;
			end
			tts_pkg::KIND_DELETED: begin
				rsp_d.slot_index = req_q.slot_id[2:0];
			end
			tts_pkg::KIND_DUE: begin
				rsp_d.slot_index = tts_pkg::slot_out(pend_idx_q);
				rsp_d.due_handle = pend_hdl_q;
			end
			default: begin
				rsp_d.slot_index = 3'd0;
				rsp_d.due_handle = 16'd0;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q        <= 32'd0;
			active_q     <= '0;
			idx_q        <= '0;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q        <= '0;
				cnt_q        <= '0;
				pend_valid_q <= 1'b0;
			end
			if (cmd.adv) begin
				idx_q <= idx_q + SW'(1);
			end
			if (cmd.tick) begin
				now_q <= now_q + 32'd1;
			end
			if (cmd.del) begin
				active_q[del_sel] <= 1'b0;
			end
			if (cmd.add_wr) begin
				active_q[idx_q] <= 1'b1;
			end
			if (cmd.take) begin
				cnt_q        <= cnt_q + CW'(1);
				pend_valid_q <= 1'b1;
				if (cur_per == 32'd0) begin
					active_q[idx_q] <= 1'b0;
				end
			end
			if (cmd.push) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
		if (cmd.add_wr) begin
			due_q[idx_q] <= now_q + req_q.delay_ticks;
			per_q[idx_q] <= req_q.period_ticks;
			hdl_q[idx_q] <= req_q.task_handle;
		end
		if (cmd.take) begin
			pend_idx_q <= idx_q;
			pend_hdl_q <= hdl_q[idx_q];
			if (cur_per != 32'd0) begin
				due_q[idx_q] <= cur_due + cur_per;
			end
		end
		if (cmd.push) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire
